/* hdl/icmp_erb_pkg.sv */
// Shared types, constants and functions of the ICMP echo request builder.
// Used by every module of the block; depends on nothing else.

package icmp_erb_pkg;

	// Packet layout: a 20-byte IPv4 header followed by an 8-byte ICMP echo request.
	localparam int IpLen    = 20;
	localparam int IcmpLen  = 8;
	localparam int PktLen   = IpLen + IcmpLen;
	localparam int IdxW     = $clog2(PktLen);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(PktLen - 1);

	// Fixed header bytes.
	localparam logic [7:0] VerIhl      = 8'h45;
	localparam logic [7:0] ProtoIcmp   = 8'h01;
	localparam logic [7:0] IcmpEchoReq = 8'h08;
	localparam logic [7:0] TotLenByte  = 8'(PktLen);

	// Constant parts of the two checksums: version/IHL/TOS word plus total length,
	// and the ICMP type/code word.
	localparam logic [15:0] IpConstSum   = {VerIhl, 8'h00} + 16'(PktLen);
	localparam logic [15:0] IcmpConstSum = {IcmpEchoReq, 8'h00};

	// Width of an unfolded sum of up to eight 16-bit words.
	localparam int SumW = 19;

	// Short queue between front and back.
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	// Configuration register indexes.
	localparam int CfgIdxW = 2;
	typedef enum logic [CfgIdxW-1:0] {
		REG_SOURCE_IP = 2'd0,
		REG_DEST_IP   = 2'd1,
		REG_TTL       = 2'd2,
		REG_ECHO_ID   = 2'd3
	} cfg_reg_t;

	localparam logic [7:0] TtlReset = 8'd64;

	typedef struct packed {
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [7:0]  ttl;
		logic [15:0] echo_id;
	} cfg_t;

	// One classified request waiting for serialization.
	typedef struct packed {
		logic [15:0] seq;
		logic [15:0] ip_csum;
		logic [15:0] icmp_csum;
	} queue_rec_t;

	// Fold an unfolded sum twice into 16 bits and complement it.
	function automatic logic [15:0] fold_csum(input logic [SumW-1:0] s);
		logic [16:0] a;
		logic [16:0] b;
		a = 17'(s[15:0]) + 17'(s[SumW-1:16]);
		b = 17'(a[15:0]) + 17'(a[16]);
		return ~b[15:0];
	endfunction

	// Byte at position idx of the packet, network order.
	function automatic logic [7:0] pkt_byte(input logic [IdxW-1:0] idx,
	                                        input queue_rec_t rec,
	                                        input cfg_t cfg);
		logic [7:0] b;
		unique case (idx)
			5'd0:  b = VerIhl;
			5'd3:  b = TotLenByte;
			5'd8:  b = cfg.ttl;
			5'd9:  b = ProtoIcmp;
			5'd10: b = rec.ip_csum[15:8];
			5'd11: b = rec.ip_csum[7:0];
			5'd12: b = cfg.source_ip[31:24];
			5'd13: b = cfg.source_ip[23:16];
			5'd14: b = cfg.source_ip[15:8];
			5'd15: b = cfg.source_ip[7:0];
			5'd16: b = cfg.dest_ip[31:24];
			5'd17: b = cfg.dest_ip[23:16];
			5'd18: b = cfg.dest_ip[15:8];
			5'd19: b = cfg.dest_ip[7:0];
			5'd20: b = IcmpEchoReq;
			5'd22: b = rec.icmp_csum[15:8];
			5'd23: b = rec.icmp_csum[7:0];
			5'd24: b = cfg.echo_id[15:8];
			5'd25: b = cfg.echo_id[7:0];
			5'd26: b = rec.seq[15:8];
			5'd27: b = rec.seq[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* hdl/icmp_erb_front.sv */
// Front of the ICMP echo request builder: accepts sequence numbers and works out
// both checksums in two stages. Depends on icmp_erb_pkg.

module icmp_erb_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [15:0]              s_tdata,
	input  icmp_erb_pkg::cfg_t       cfg,
	output logic                     push_valid,
	input  logic                     push_ready,
	output icmp_erb_pkg::queue_rec_t push_rec
);

	logic                              valid_s1;
	logic [15:0]                       seq_s1;
	logic                              valid_s2;
	logic [15:0]                       seq_s2;
	logic [icmp_erb_pkg::SumW-1:0]     ip_sum_s2;
	logic [icmp_erb_pkg::SumW-1:0]     icmp_sum_s2;
	logic                              ready_s1;
	logic                              ready_s2;
	logic [icmp_erb_pkg::SumW-1:0]     ip_sum;
	logic [icmp_erb_pkg::SumW-1:0]     icmp_sum;

	assign ready_s2 = !valid_s2 || push_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	// Unfolded sums; the checksum fields count as zero.
	always_comb begin
		ip_sum = icmp_erb_pkg::SumW'(icmp_erb_pkg::IpConstSum)
		       + icmp_erb_pkg::SumW'({cfg.ttl, icmp_erb_pkg::ProtoIcmp})
		       + icmp_erb_pkg::SumW'(cfg.source_ip[31:16])
		       + icmp_erb_pkg::SumW'(cfg.source_ip[15:0])
		       + icmp_erb_pkg::SumW'(cfg.dest_ip[31:16])
		       + icmp_erb_pkg::SumW'(cfg.dest_ip[15:0]);
		icmp_sum = icmp_erb_pkg::SumW'(icmp_erb_pkg::IcmpConstSum)
		         + icmp_erb_pkg::SumW'(cfg.echo_id)
		         + icmp_erb_pkg::SumW'(seq_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			seq_s1 <= s_tdata;
		end
		if (ready_s2 && valid_s1) begin
			seq_s2      <= seq_s1;
			ip_sum_s2   <= ip_sum;
			icmp_sum_s2 <= icmp_sum;
		end
	end

	assign push_valid         = valid_s2;
	assign push_rec.seq       = seq_s2;
	assign push_rec.ip_csum   = icmp_erb_pkg::fold_csum(ip_sum_s2);
	assign push_rec.icmp_csum = icmp_erb_pkg::fold_csum(icmp_sum_s2);

`ifndef NO_ASSERTIONS
	// A request stuck in the second stage is not lost while the queue is full.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !push_ready |=> valid_s2)
		else $error("front stage two dropped a stalled request");
`endif

endmodule

/* hdl/icmp_erb_queue.sv */
// Short register queue between front and back of the ICMP echo request builder.
// Depends on icmp_erb_pkg.

module icmp_erb_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push_valid,
	output logic                     push_ready,
	input  icmp_erb_pkg::queue_rec_t push_rec,
	output logic                     pop_valid,
	input  logic                     pop,
	output icmp_erb_pkg::queue_rec_t pop_rec
);

	icmp_erb_pkg::queue_rec_t             entries_q [icmp_erb_pkg::QueueDepth];
	logic [icmp_erb_pkg::QPtrW-1:0]       wr_ptr_q;
	logic [icmp_erb_pkg::QPtrW-1:0]       rd_ptr_q;
	logic [icmp_erb_pkg::QCntW-1:0]       count_q;
	logic                                 do_push;
	logic                                 do_pop;

	assign push_ready = count_q != icmp_erb_pkg::QCntW'(icmp_erb_pkg::QueueDepth);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_rec    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_rec;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= icmp_erb_pkg::QCntW'(icmp_erb_pkg::QueueDepth))
		else $error("queue occupancy beyond its depth");
`endif

endmodule

/* hdl/icmp_erb_back.sv */
// Back of the ICMP echo request builder: takes requests from the queue and sends
// their 28 packet bytes through an output register. Depends on icmp_erb_pkg.

module icmp_erb_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pop_valid,
	output logic                     pop,
	input  icmp_erb_pkg::queue_rec_t pop_rec,
	input  icmp_erb_pkg::cfg_t       cfg,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [7:0]               m_tdata,
	output logic                     m_tlast
);

	icmp_erb_pkg::queue_rec_t         cur_q;
	logic                             busy_q;
	logic [icmp_erb_pkg::IdxW-1:0]    idx_q;
	logic                             out_valid_q;
	logic [7:0]                       out_data_q;
	logic                             out_last_q;
	logic                             advance;
	logic                             at_last;

	assign advance = !out_valid_q || m_tready;
	assign at_last = idx_q == icmp_erb_pkg::LastIdx;
	// Take the next request when idle or as the last byte goes into the output register.
	assign pop     = pop_valid && (!busy_q || (advance && at_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q && advance) begin
				if (at_last) begin
					busy_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_rec;
		end
		if (busy_q && advance) begin
			out_data_q <= icmp_erb_pkg::pkt_byte(idx_q, cur_q, cfg);
			out_last_q <= at_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_valid_q && out_last_q;

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= icmp_erb_pkg::LastIdx)
		else $error("byte index beyond end of packet");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a packet");

	a_pop_safe: assert property (@(posedge clk) disable iff (!arst_n)
		pop && busy_q |-> advance && at_last)
		else $error("request taken while a packet is still being sent");
`endif

endmodule

/* hdl/icmp_echo_request_builder_top.sv */
// Top level of the ICMP echo request builder: configuration registers and the
// front, queue and back parts. Depends on icmp_erb_pkg and the icmp_erb_* modules.
//
// Usage: each request on the slave stream (s_tdata = 16-bit echo sequence number)
// turns into one 28-byte IPv4 ICMP echo request packet on the master stream, one
// byte per beat in network order, with m_tlast high on the 28th byte.
// The front takes a request and computes the IPv4 header checksum and the ICMP
// checksum over two register stages, then places the request in a four-entry
// queue. The back takes requests from the queue and drives the bytes through an
// output register, so the two sides stall independently.
// A request passes through the two front stages, a queue entry and the back's
// request register before its first byte is loaded into the output register.
// Packets follow each other with no idle beat while requests are waiting, and
// new requests are accepted while earlier packets are still being sent until
// the queue and front are full.
// Configuration is written through cfg_we/cfg_index/cfg_data and must only be
// changed while no packet is pending; header fields are read from the registers
// while a packet is sent.
// Reset (arst_n low) empties the pipeline and queue and loads the registers with
// source 0, destination 0, TTL 64 and identifier 0.
// When the receiver holds m_tready low, the current byte stays on m_tdata and the
// block keeps accepting requests until its internal storage is full.

module icmp_echo_request_builder_top (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sequence_number
	// Packet byte stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] packet_byte
	output logic        m_tlast,   // last_byte
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	icmp_erb_pkg::cfg_t       cfg_q;
	logic                     push_valid;
	logic                     push_ready;
	icmp_erb_pkg::queue_rec_t push_rec;
	logic                     pop_valid;
	logic                     pop;
	icmp_erb_pkg::queue_rec_t pop_rec;

	// Configuration registers; only the register's own width is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_ip <= '0;
			cfg_q.dest_ip   <= '0;
			cfg_q.ttl       <= icmp_erb_pkg::TtlReset;
			cfg_q.echo_id   <= '0;
		end else if (cfg_we) begin
			unique case (icmp_erb_pkg::cfg_reg_t'(cfg_index))
				icmp_erb_pkg::REG_SOURCE_IP: cfg_q.source_ip <= cfg_data;
				icmp_erb_pkg::REG_DEST_IP:   cfg_q.dest_ip   <= cfg_data;
				icmp_erb_pkg::REG_TTL:       cfg_q.ttl       <= cfg_data[7:0];
				icmp_erb_pkg::REG_ECHO_ID:   cfg_q.echo_id   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	icmp_erb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec)
	);

	icmp_erb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_rec    (pop_rec)
	);

	icmp_erb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_rec   (pop_rec),
		.cfg       (cfg_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

/* verif/icmp_echo_request_builder_top_test.sv */
// Self-checking bench for icmp_echo_request_builder_top: drives sequence numbers,
// predicts each 28-byte echo request packet and checks it byte by byte.
// Depends on icmp_erb_pkg (register indexes) and the block's RTL only.

module icmp_echo_request_builder_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	// Fixed layout of the packet, kept independent of the RTL package.
	localparam int          PACKET_BYTES  = 28;
	localparam logic [7:0]  TTL_AT_RESET  = 8'd64;
	localparam int          DRAIN_CYCLES  = 8;     // pipeline depth plus margin
	localparam int          WATCHDOG_MAX  = 1000;  // cycles with no transfer at all
	localparam int          RANDOM_PHASES = 5;
	localparam int          PHASE_ITEMS   = 42;

	// Header fields as the bench believes the registers hold them.
	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  ttl;
		logic [15:0] ident;
	} header_regs_t;

	// One expected byte of a packet.
	typedef struct packed {
		logic [7:0] octet;
		logic       last;
		logic [4:0] pos;
	} packet_octet_t;

	// One directed step. When load is set the registers are rewritten first;
	// when typed is set the checksums below are the expected ones, otherwise
	// the predictor supplies them.
	typedef struct packed {
		logic        load;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] ttl_word;
		logic [31:0] id_word;
		logic [15:0] seq;
		logic        typed;
		logic [15:0] ip_ck;
		logic [15:0] icmp_ck;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	header_regs_t  hdr_regs;
	packet_octet_t octets_due[$];
	packet_octet_t want;
	int            errors = 0;
	int            requests_sent = 0;
	int            octets_checked = 0;
	int            settings_applied = 0;
	int            idle_cycles = 0;
	int            rx_hold = 0;
	bit            rx_stalls = 1'b0;

	icmp_echo_request_builder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The whole packet as one vector, first byte in the top bits. The IPv4
	// header fills the upper 160 bits and the ICMP part the lower 64.
	function automatic logic [PACKET_BYTES*8-1:0] packet_image(input header_regs_t r,
	                                                           input logic [15:0] seq,
	                                                           input logic [15:0] ip_ck,
	                                                           input logic [15:0] icmp_ck);
		return {8'h45, 8'h00, 16'd28, 16'h0000, 16'h0000, r.ttl, 8'h01, ip_ck,
		        r.src, r.dst, 8'h08, 8'h00, icmp_ck, r.ident, seq};
	endfunction

	// Internet checksum over the first count 16-bit words of a left-aligned
	// header: plain sum, folded until the carries are gone, then inverted.
	function automatic logic [15:0] internet_checksum(input logic [159:0] words,
	                                                  input int count);
		logic [19:0] acc;
		acc = '0;
		for (int k = 0; k < count; k++)
			acc += 20'(words[159 - 16*k -: 16]);
		while (acc[19:16] != 4'd0)
			acc = 20'(acc[15:0]) + 20'(acc[19:16]);
		return ~acc[15:0];
	endfunction

	// Expected packet for one request under the current register contents.
	// The checksums are taken over the headers with their checksum fields zero.
	function automatic logic [PACKET_BYTES*8-1:0] predict_packet(input header_regs_t r,
	                                                             input logic [15:0] seq);
		logic [PACKET_BYTES*8-1:0] blank;
		blank = packet_image(r, seq, 16'h0000, 16'h0000);
		return packet_image(r, seq, internet_checksum(blank[223:64], 10),
		                    internet_checksum({blank[63:0], 96'b0}, 4));
	endfunction

	// Sender gap: none when disabled; else mostly none, sometimes short, rarely a long pause.
	function automatic int pick_gap(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one request, wait for the handshake, then queue its 28 bytes.
	// s_tvalid stays high unless a gap follows, so back-to-back requests
	// never see valid drop.
	task automatic send_request(input logic [15:0] seq,
	                            input logic [PACKET_BYTES*8-1:0] image,
	                            input int gap);
		s_tvalid <= 1'b1;
		s_tdata  <= seq;
		do @(posedge clk); while (!s_tready);
		for (int k = 0; k < PACKET_BYTES; k++)
			octets_due.push_back('{octet: image[PACKET_BYTES*8-1 - 8*k -: 8],
			                       last: (k == PACKET_BYTES - 1), pos: 5'(k)});
		requests_sent++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering requests and wait until every pending byte has come out.
	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		while (octets_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Rewrite all four registers while the block is idle. Values wider than
	// a register are written raw; only the register's low bits are kept.
	task automatic program_regs(input logic [31:0] src, input logic [31:0] dst,
	                            input logic [31:0] ttl_word, input logic [31:0] id_word);
		settle_pipeline();
		cfg_we    <= 1'b1;
		cfg_index <= icmp_erb_pkg::REG_SOURCE_IP;
		cfg_data  <= src;
		@(posedge clk);
		cfg_index <= icmp_erb_pkg::REG_DEST_IP;
		cfg_data  <= dst;
		@(posedge clk);
		cfg_index <= icmp_erb_pkg::REG_TTL;
		cfg_data  <= ttl_word;
		@(posedge clk);
		cfg_index <= icmp_erb_pkg::REG_ECHO_ID;
		cfg_data  <= id_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		hdr_regs = '{src: src, dst: dst, ttl: ttl_word[7:0], ident: id_word[15:0]};
		settings_applied++;
	endtask

	// Receiver: random back-pressure, mostly short stalls with an occasional
	// long one, switched off entirely in some phases.
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			m_tready <= 1'b0;
			rx_hold  <= rx_hold - 1;
		end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
			m_tready <= 1'b0;
			rx_hold  <= ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40)
			                                         : $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Every byte taken from the block is matched against the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (octets_due.size() == 0) begin
				$error("unexpected packet byte 0x%02h (last=%0b)", m_tdata, m_tlast);
				errors++;
			end else begin
				want = octets_due.pop_front();
				octets_checked++;
				if (m_tdata !== want.octet) begin
					$error("packet_byte at offset %0d: expected 0x%02h, got 0x%02h",
					       want.pos, want.octet, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_byte at offset %0d: expected %0b, got %0b",
					       want.pos, want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog: a run that stops moving on both streams is a failure.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("[icmp_echo_request_builder_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		step_row_t   rows[$];
		step_row_t   row;
		logic [15:0] seq;
		logic [15:0] ping_seq;
		logic [31:0] src;
		logic [31:0] dst;
		bit          tx_idle;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = icmp_erb_pkg::REG_SOURCE_IP;
		cfg_data  = '0;
		hdr_regs  = '{src: 32'h0, dst: 32'h0, ttl: TTL_AT_RESET, ident: 16'h0};
		rx_stalls = 1'b1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed steps. Columns: load, src, dst, ttl word, id word, seq,
		// typed, IPv4 checksum, ICMP checksum.
		// Reset values: both checksums follow from the constant fields and the reset TTL alone.
		rows.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0000, 1'b1, 16'h7ae2, 16'hf7ff});
		// All-ones sequence number: the ICMP sum wraps back to the same checksum.
		rows.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hffff, 1'b1, 16'h7ae2, 16'hf7ff});
		rows.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h8000, 1'b0, 16'h0, 16'h0});
		rows.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0001, 1'b0, 16'h0, 16'h0});
		rows.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h5a5a, 1'b0, 16'h0, 16'h0});
		// Every register at its maximum: several carries to fold back in.
		rows.push_back('{1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
		                 16'hffff, 1'b1, 16'hbbe1, 16'hf7ff});
		rows.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0000, 1'b0, 16'h0, 16'h0});
		// Over-wide writes that leave a TTL of zero and an identifier of zero.
		rows.push_back('{1'b1, 32'h0, 32'h0, 32'h00000100, 32'habcd0000,
		                 16'h1234, 1'b1, 16'hbae2, 16'he5cb});
		rows.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hedcb, 1'b0, 16'h0, 16'h0});
		// Smallest legal TTL with ordinary addresses.
		rows.push_back('{1'b1, 32'hc0a80001, 32'h08080808, 32'h00000001, 32'h00001234,
		                 16'h0001, 1'b0, 16'h0, 16'h0});
		rows.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hfffe, 1'b0, 16'h0, 16'h0});
		rows.push_back('{1'b1, 32'hffffffff, 32'h00000000, 32'h00000080, 32'h00008000,
		                 16'h7fff, 1'b0, 16'h0, 16'h0});
		rows.push_back('{1'b1, 32'h00000000, 32'hffffffff, 32'h000000ff, 32'h00000001,
		                 16'h0100, 1'b0, 16'h0, 16'h0});
		rows.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h00ff, 1'b0, 16'h0, 16'h0});

		foreach (rows[i]) begin
			row = rows[i];
			if (row.load)
				program_regs(row.src, row.dst, row.ttl_word, row.id_word);
			if (row.typed)
				send_request(row.seq, packet_image(hdr_regs, row.seq, row.ip_ck, row.icmp_ck),
				             pick_gap(1'b1));
			else
				send_request(row.seq, predict_packet(hdr_regs, row.seq), pick_gap(1'b1));
		end

		// Random phases. Each starts from fresh register contents, often at an
		// extreme. The first phase runs with no idling on either side, later
		// ones idle the sender, the receiver or both.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0:       src = 32'h00000000;
				1:       src = 32'hffffffff;
				default: src = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0:       dst = 32'h00000000;
				1:       dst = 32'hffffffff;
				default: dst = $urandom;
			endcase
			program_regs(src, dst, $urandom, $urandom);
			tx_idle   = (phase != 0) && (phase != 3);
			rx_stalls <= (phase != 0) && (phase != 2);
			ping_seq  = $urandom_range(0, 65535);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Half the time a running ping counter, which wraps through 0xffff now
				// and then; the rest are arbitrary sequence numbers.
				if ($urandom_range(0, 1) == 0) begin
					seq      = ping_seq;
					ping_seq = ping_seq + 16'd1;
				end else begin
					seq = $urandom_range(0, 65535);
				end
				send_request(seq, predict_packet(hdr_regs, seq), pick_gap(tx_idle));
				// Halfway through, let the block run completely dry once.
				if (n == PHASE_ITEMS / 2)
					settle_pipeline();
			end
		end

		settle_pipeline();

		$display("Checked %0d echo request packets (%0d bytes) under %0d register settings,",
		         requests_sent, octets_checked, settings_applied);
		$display("with reset, extreme and random headers and random stalls on both streams.");
		if (errors == 0)
			$display("[icmp_echo_request_builder_top] OK");
		else
			$display("[icmp_echo_request_builder_top] ERROR");
		$finish;
	end

endmodule
